// ===== rtl/mtcc_pkg.sv =====
`default_nettype none

package mtcc_pkg;

	// One particle of a vertex, as it arrives on the request channel.
	typedef struct packed {
		logic signed [31:0] particle_code;
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic signed [31:0] momentum_x;
		logic signed [31:0] momentum_y;
		logic signed [31:0] momentum_z;
		logic [31:0]        total_energy;
		logic [31:0]        rest_mass;
		logic               last_of_vertex;
	} in_item_t;

	// Verdict for one vertex.
	typedef struct packed {
		logic        partially_contained;
		logic [15:0] particle_count;
	} out_item_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_LOSS_RATE = 1'b0,
		CFG_RADIUS    = 1'b1
	} cfg_index_t;

	localparam logic [31:0]        LOSS_RATE_RESET = 32'd13107200;
	localparam logic [30:0]        RADIUS_RESET    = 31'd17700000;
	localparam logic signed [31:0] MUON_CODE       = 32'sd13;
	localparam logic [31:0]        KEV_TO_UM       = 32'd1000;
	localparam logic [15:0]        COUNT_MAX       = 16'hFFFF;
	localparam int                 SQRT_STEPS      = 32;
	localparam int                 DIV_STEPS       = 64;
	localparam int                 UNIT_SHIFT      = 30;
	localparam int                 LEN_BITS        = 34;
	localparam int                 LEN_SPLIT       = 17;
	localparam logic [1:0]         LAST_AXIS       = 2'd2;

	// Operand pair for the shared multiplier.
	typedef enum logic [2:0] {
		MS_PMAG,
		MS_EMAG,
		MS_RAD,
		MS_KIN,
		MS_LEN_LO,
		MS_LEN_HI
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_CLR,
		ACC_ADD,
		ACC_ADD_HI
	} acc_op_t;

	typedef enum logic [0:0] {
		DS_LEN,
		DS_UNIT
	} div_src_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_SQ_CHK,
		ST_SQRT,
		ST_KIN_MUL,
		ST_LEN_INIT,
		ST_DIV,
		ST_LEN_CHK,
		ST_UNIT_INIT,
		ST_UNIT_LD,
		ST_D_LO,
		ST_D_HI,
		ST_D_ADD,
		ST_D_END,
		ST_SS_MUL,
		ST_SS_ACC,
		ST_RR_MUL,
		ST_RR_CHK,
		ST_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     sqrt_init;
		logic     sqrt_step;
		logic     div_init;
		div_src_t div_src;
		logic     div_step;
		logic     len_load;
		logic     unit_load;
		logic     end_load;
		logic     flag_set;
		logic     emit;
		logic [1:0] axis;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_muon;
		logic last;
		logic sq_zero;
		logic len_over;
		logic end_out;
		logic sum_over;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mtcc_ctrl.sv =====
`default_nettype none

module mtcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mtcc_pkg::dp_sts_t sts,
	output mtcc_pkg::dp_cmd_t cmd
);
	import mtcc_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic [5:0] cnt_q, cnt_d;
	logic       div_unit_q, div_unit_d;

	// State and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			cnt_q      <= '0;
			div_unit_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			cnt_q      <= cnt_d;
			div_unit_q <= div_unit_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		div_unit_d  = div_unit_q;
		in_stall    = 1'b1;
		cmd         = '0;
		cmd.mul_sel = MS_PMAG;
		cmd.acc_op  = ACC_HOLD;
		cmd.div_src = DS_LEN;
		cmd.axis    = idx_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.acc_op  = ACC_CLR;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				idx_d   = '0;
				state_d = sts.is_muon ? ST_SQ_MUL : ST_FIN;
			end
			ST_SQ_MUL: begin
				cmd.mul_sel = MS_PMAG;
				state_d     = ST_SQ_ACC;
			end
			ST_SQ_ACC: begin
				cmd.acc_op = ACC_ADD;
				if (idx_q == LAST_AXIS) begin
					idx_d   = '0;
					state_d = ST_SQ_CHK;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = ST_SQ_MUL;
				end
			end
			ST_SQ_CHK: begin
				if (sts.sq_zero) begin
					state_d = ST_FIN;
				end else begin
					cmd.sqrt_init = 1'b1;
					cnt_d         = '0;
					state_d       = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 6'd1;
				if (cnt_q == 6'(SQRT_STEPS - 1)) begin
					state_d = ST_KIN_MUL;
				end
			end
			ST_KIN_MUL: begin
				cmd.mul_sel = MS_KIN;
				state_d     = ST_LEN_INIT;
			end
			ST_LEN_INIT: begin
				cmd.div_init = 1'b1;
				cmd.div_src  = DS_LEN;
				div_unit_d   = 1'b0;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					state_d = div_unit_q ? ST_UNIT_LD : ST_LEN_CHK;
				end
			end
			ST_LEN_CHK: begin
				if (sts.len_over) begin
					cmd.flag_set = 1'b1;
					state_d      = ST_FIN;
				end else begin
					cmd.len_load = 1'b1;
					idx_d        = '0;
					state_d      = ST_UNIT_INIT;
				end
			end
			ST_UNIT_INIT: begin
				cmd.div_init = 1'b1;
				cmd.div_src  = DS_UNIT;
				div_unit_d   = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_UNIT_LD: begin
				cmd.unit_load = 1'b1;
				state_d       = ST_D_LO;
			end
			ST_D_LO: begin
				cmd.mul_sel = MS_LEN_LO;
				cmd.acc_op  = ACC_CLR;
				state_d     = ST_D_HI;
			end
			ST_D_HI: begin
				cmd.mul_sel = MS_LEN_HI;
				cmd.acc_op  = ACC_ADD;
				state_d     = ST_D_ADD;
			end
			ST_D_ADD: begin
				cmd.acc_op = ACC_ADD_HI;
				state_d    = ST_D_END;
			end
			ST_D_END: begin
				if (sts.end_out) begin
					cmd.flag_set = 1'b1;
					state_d      = ST_FIN;
				end else begin
					cmd.end_load = 1'b1;
					if (idx_q == LAST_AXIS) begin
						idx_d   = '0;
						state_d = ST_SS_MUL;
					end else begin
						idx_d   = idx_q + 2'd1;
						state_d = ST_UNIT_INIT;
					end
				end
			end
			ST_SS_MUL: begin
				cmd.mul_sel = MS_EMAG;
				if (idx_q == 2'd0) begin
					cmd.acc_op = ACC_CLR;
				end
				state_d = ST_SS_ACC;
			end
			ST_SS_ACC: begin
				cmd.acc_op = ACC_ADD;
				if (idx_q == LAST_AXIS) begin
					state_d = ST_RR_MUL;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = ST_SS_MUL;
				end
			end
			ST_RR_MUL: begin
				cmd.mul_sel = MS_RAD;
				state_d     = ST_RR_CHK;
			end
			ST_RR_CHK: begin
				cmd.flag_set = sts.sum_over;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.last) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/mtcc_dp.sv =====
`default_nettype none

module mtcc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtcc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mtcc_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  mtcc_pkg::cfg_index_t cfg_index,
	input  logic [31:0]          cfg_data,
	input  mtcc_pkg::dp_cmd_t    cmd,
	output mtcc_pkg::dp_sts_t    sts
);
	import mtcc_pkg::*;

	in_item_t    item_q;
	logic [31:0] rate_q;
	logic [30:0] rad_q;
	logic        flag_q;
	logic [15:0] count_q;
	logic [63:0] prod_q;
	logic [64:0] acc_q;
	logic [63:0] sq_n_q, sq_res_q, sq_bit_q;
	logic [63:0] num_q;
	logic [31:0] rem_q, div_q;
	logic [LEN_BITS-1:0] len_q;
	logic [30:0] unit_q;
	logic [31:0] em_q [3];
	out_item_t   out_q;
	logic        out_valid_q;

	logic signed [31:0] mom_sel, vtx_sel;
	logic [31:0] pm_sel, kin, mul_a, mul_b;
	logic [63:0] mul_p, sq_try;
	logic [32:0] rem_try;
	logic        div_ge;
	logic [LEN_BITS-1:0] disp;
	logic signed [35:0] end_pos;
	logic [35:0] end_mag;

	// Axis selection of the captured particle.
	always_comb begin
		case (cmd.axis)
			2'd0: begin
				mom_sel = item_q.momentum_x;
				vtx_sel = item_q.vertex_x;
			end
			2'd1: begin
				mom_sel = item_q.momentum_y;
				vtx_sel = item_q.vertex_y;
			end
			default: begin
				mom_sel = item_q.momentum_z;
				vtx_sel = item_q.vertex_z;
			end
		endcase
	end

	assign pm_sel = mom_sel[31] ? 32'(-mom_sel) : 32'(mom_sel);
	assign kin    = (item_q.total_energy > item_q.rest_mass) ?
		(item_q.total_energy - item_q.rest_mass) : 32'd0;

	// Shared multiplier operands.
	always_comb begin
		case (cmd.mul_sel)
			MS_PMAG: begin
				mul_a = pm_sel;
				mul_b = pm_sel;
			end
			MS_EMAG: begin
				mul_a = em_q[cmd.axis];
				mul_b = em_q[cmd.axis];
			end
			MS_RAD: begin
				mul_a = {1'b0, rad_q};
				mul_b = {1'b0, rad_q};
			end
			MS_KIN: begin
				mul_a = kin;
				mul_b = KEV_TO_UM;
			end
			MS_LEN_LO: begin
				mul_a = {1'b0, unit_q};
				mul_b = 32'(len_q[LEN_SPLIT-1:0]);
			end
			MS_LEN_HI: begin
				mul_a = {1'b0, unit_q};
				mul_b = 32'(len_q[LEN_BITS-1:LEN_SPLIT]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// Product register and accumulator.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (cmd.acc_op)
			ACC_CLR:    acc_q <= '0;
			ACC_ADD:    acc_q <= acc_q + 65'(prod_q);
			ACC_ADD_HI: acc_q <= acc_q + (65'(prod_q) << LEN_SPLIT);
			default:    acc_q <= acc_q;
		endcase
	end

	// Integer square root, one result bit per step.
	assign sq_try = sq_res_q + sq_bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sq_n_q   <= acc_q[63:0];
			sq_res_q <= '0;
			sq_bit_q <= 64'd1 << 62;
		end else if (cmd.sqrt_step) begin
			if (sq_n_q >= sq_try) begin
				sq_n_q   <= sq_n_q - sq_try;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// Restoring divider, one quotient bit per step; quotient shifts into num_q.
	assign rem_try = {rem_q, num_q[63]};
	assign div_ge  = rem_try >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			if (cmd.div_src == DS_LEN) begin
				num_q <= {6'd0, prod_q[41:0], 16'd0};
				div_q <= (rate_q == 32'd0) ? 32'd1 : rate_q;
			end else begin
				num_q <= {2'd0, pm_sel, 30'd0};
				div_q <= sq_res_q[31:0];
			end
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? 32'(rem_try - {1'b0, div_q}) : rem_try[31:0];
			num_q <= {num_q[62:0], div_ge};
		end
		if (cmd.len_load) begin
			len_q <= num_q[LEN_BITS-1:0];
		end
		if (cmd.unit_load) begin
			unit_q <= num_q[30:0];
		end
	end

	// Track end on the current axis.
	assign disp    = acc_q[UNIT_SHIFT +: LEN_BITS];
	assign end_pos = 36'(vtx_sel) + (mom_sel[31] ? -$signed(36'(disp)) : $signed(36'(disp)));
	assign end_mag = end_pos[35] ? 36'(-end_pos) : 36'(end_pos);

	always_ff @(posedge clk) begin
		if (cmd.end_load) begin
			em_q[cmd.axis] <= end_mag[31:0];
		end
	end

	// Captured particle.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	// Configuration, vertex state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= LOSS_RATE_RESET;
			rad_q       <= RADIUS_RESET;
			flag_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOSS_RATE: rate_q <= cfg_data;
					CFG_RADIUS:    rad_q  <= cfg_data[30:0];
					default:       rate_q <= rate_q;
				endcase
			end
			if (cmd.capture && count_q != COUNT_MAX) begin
				count_q <= count_q + 16'd1;
			end
			if (cmd.flag_set) begin
				flag_q <= 1'b1;
			end
			if (cmd.emit) begin
				flag_q      <= 1'b0;
				count_q     <= '0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.partially_contained <= flag_q;
			out_q.particle_count      <= count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status to the controller.
	assign sts.is_muon  = (item_q.particle_code == MUON_CODE) ||
		(item_q.particle_code == -MUON_CODE);
	assign sts.last     = item_q.last_of_vertex;
	assign sts.sq_zero  = (acc_q == '0);
	assign sts.len_over = |num_q[63:LEN_BITS];
	assign sts.end_out  = end_mag > 36'(rad_q);
	assign sts.sum_over = acc_q[63:0] > prod_q;
	assign sts.out_free = !out_valid_q || !out_stall;

`ifndef SYNTH
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("result appeared without an emit command");
	a_vertex_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (count_q == '0 && !flag_q))
		else $error("vertex state not cleared after emit");
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (div_q != '0))
		else $error("divider stepping with a zero divisor");
`endif

endmodule

`default_nettype wire

// ===== rtl/muon_track_containment_check_unit.sv =====
`default_nettype none

// Muon track containment check. Particles of one vertex arrive one request
// at a time; the request marked last_of_vertex produces one result with the
// containment flag and the saturating particle count. A particle that is not
// a muon skips the track work. For a muon, one 32-step square root runs on
// the root unit and four 64-step divisions (track length, then one per
// axis) run on a single shared restoring divider, with one shared 32x32
// multiplier for all products; an early escape ends the work sooner. The
// result sits in an output register, so a new request is taken while a
// result still waits. Configuration writes are always ready.
module muon_track_containment_check_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mtcc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mtcc_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  mtcc_pkg::cfg_index_t cfg_index,
	input  logic [31:0]          cfg_data
);
	import mtcc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	mtcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mtcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire
